// ===== rtl/slip_framing_codec_defines.svh =====
// ----------------------------------------------------------------------------
// slip framing codec assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SLIP_FRAMING_CODEC_DEFINES_SVH
`define SLIP_FRAMING_CODEC_DEFINES_SVH

// same-cycle implication, off during reset
`define SFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slip codec check failed");

// next-cycle implication, off during reset
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slip codec check failed");

// next-cycle implication, active through reset
`define SFC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slip codec check failed");

`endif

// ===== rtl/slfc_pkg.sv =====
// ----------------------------------------------------------------------------
// slfc_pkg
// types, line codes and limits shared by the slip framing codec
// ----------------------------------------------------------------------------
package slfc_pkg;

  // largest receive frame the block will ever keep
  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned LEN_W           = 12;
  localparam int unsigned LEN_MAX         = (1 << LEN_W) - 1;
  localparam int unsigned CAP_INT         =
    (MAX_FRAME_BYTES < LEN_MAX) ? MAX_FRAME_BYTES : LEN_MAX;
  localparam logic [LEN_W-1:0] LIM_CAP    = CAP_INT[LEN_W-1:0];

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 12'd1006;

  // line codes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // input selector codes
  localparam logic [1:0] FUNC_RX_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TX_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TX_EMPTY = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_RX_BYTE  = 2'd0;
  localparam logic [1:0] KIND_RX_FRAME = 2'd1;
  localparam logic [1:0] KIND_TX_BYTE  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       byte_out;
    logic [LEN_W-1:0] frame_length;
    logic             last_of_run;
  } out_item_t;

  // one classified item: up to four results of one kind
  typedef struct packed {
    logic [2:0]       count;
    logic [1:0]       kind;
    logic [3:0][7:0]  bytes;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

// ===== rtl/slfc_queue.sv =====
// ----------------------------------------------------------------------------
// slfc_queue
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module slfc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  slfc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output slfc_pkg::cmd_t pop_cmd,
  output logic          valid
);

  slfc_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/slfc_front.sv =====
// ----------------------------------------------------------------------------
// slfc_front
// accepts items, tracks codec state and classifies each item that gives results into a command
// ----------------------------------------------------------------------------
module slfc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  slfc_pkg::in_item_t           item,
  input  logic                         cfg_we,
  input  logic [slfc_pkg::LEN_W-1:0]   cfg_wdata,
  output slfc_pkg::cmd_t               cmd,
  output logic                         cmd_valid
);

  logic [slfc_pkg::LEN_W-1:0] max_payload_r;
  logic                       esc_r, esc_nxt;
  logic [slfc_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic                       txp_r, txp_nxt;

  logic [slfc_pkg::LEN_W-1:0] lim;
  logic                       rx_store;
  logic [7:0]                 rx_val;
  logic [2:0]                 n;
  logic [7:0]                 b;

  assign b = item.data_byte;

  // classification and next state
  always_comb begin
    lim = max_payload_r;
    if (slfc_pkg::LIM_CAP < lim) begin
      lim = slfc_pkg::LIM_CAP;
    end
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    txp_nxt  = txp_r;
    rx_store = 1'b0;
    rx_val   = b;
    n        = 3'd0;
    cmd      = '0;
    case (item.func)
      slfc_pkg::FUNC_RX_BYTE: begin
        cmd.kind = slfc_pkg::KIND_RX_BYTE;
        if (esc_r) begin
          rx_store = 1'b1;
          if (b == slfc_pkg::SLIP_ESC_END) begin
            rx_val = slfc_pkg::SLIP_END;
          end else if (b == slfc_pkg::SLIP_ESC_ESC) begin
            rx_val = slfc_pkg::SLIP_ESC;
          end
          esc_nxt = (b == slfc_pkg::SLIP_ESC);
        end else if (b == slfc_pkg::SLIP_ESC) begin
          esc_nxt = 1'b1;
        end else if (b == slfc_pkg::SLIP_END) begin
          // bare end closes a non-empty frame
          if (cnt_r != '0) begin
            cmd.kind = slfc_pkg::KIND_RX_FRAME;
            cmd.len  = cnt_r;
            n        = 3'd1;
            cnt_nxt  = '0;
          end
          esc_nxt = 1'b0;
        end else begin
          rx_store = 1'b1;
          esc_nxt  = 1'b0;
        end
        // store unless the frame is at its limit
        if (rx_store && (cnt_r < lim)) begin
          cnt_nxt      = cnt_r + 1'b1;
          cmd.bytes[0] = rx_val;
          n            = 3'd1;
        end
      end
      slfc_pkg::FUNC_TX_BYTE: begin
        cmd.kind = slfc_pkg::KIND_TX_BYTE;
        if (!txp_r) begin
          cmd.bytes[n[1:0]] = slfc_pkg::SLIP_END;
          n                 = n + 3'd1;
          txp_nxt           = 1'b1;
        end
        if (b == slfc_pkg::SLIP_END || b == slfc_pkg::SLIP_ESC) begin
          cmd.bytes[n[1:0]] = slfc_pkg::SLIP_ESC;
          n                 = n + 3'd1;
          cmd.bytes[n[1:0]] = (b == slfc_pkg::SLIP_END) ? slfc_pkg::SLIP_ESC_END
                                                         : slfc_pkg::SLIP_ESC_ESC;
          n                 = n + 3'd1;
        end else begin
          cmd.bytes[n[1:0]] = b;
          n                 = n + 3'd1;
        end
        if (item.last_of_packet) begin
          cmd.bytes[n[1:0]] = slfc_pkg::SLIP_END;
          n                 = n + 3'd1;
          txp_nxt           = 1'b0;
        end
      end
      slfc_pkg::FUNC_TX_EMPTY: begin
        cmd.kind     = slfc_pkg::KIND_TX_BYTE;
        cmd.bytes[0] = slfc_pkg::SLIP_END;
        cmd.bytes[1] = slfc_pkg::SLIP_END;
        n            = 3'd2;
        txp_nxt      = 1'b0;
      end
      default: begin
      end
    endcase
    cmd.count = n;
  end

  assign cmd_valid = accept && (n != 3'd0);

  // codec state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      cnt_r <= '0;
      txp_r <= 1'b0;
    end else if (accept) begin
      esc_r <= esc_nxt;
      cnt_r <= cnt_nxt;
      txp_r <= txp_nxt;
    end
  end

  // payload limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= slfc_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

endmodule

// ===== rtl/slfc_back.sv =====
// ----------------------------------------------------------------------------
// slfc_back
// expands queued commands into result items, one per cycle while res_pop is high
// ----------------------------------------------------------------------------
module slfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  slfc_pkg::cmd_t     q_cmd,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_pop,
  output slfc_pkg::out_item_t res
);

  slfc_pkg::cmd_t cur_r, cur_nxt;
  logic           vld_r, vld_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           is_last, take, done, load;

  assign is_last = (({1'b0, idx_r} + 3'd1) == cur_r.count);
  assign take    = res_pop && vld_r;
  assign done    = take && is_last;
  assign load    = (!vld_r || done) && q_valid;
  assign q_pop   = load;

  // current command sequencing
  always_comb begin
    cur_nxt = cur_r;
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      cur_nxt = q_cmd;
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // result fields
  assign res_valid        = vld_r;
  assign res.kind         = cur_r.kind;
  assign res.byte_out     = cur_r.bytes[idx_r];
  assign res.frame_length = cur_r.len;
  assign res.last_of_run  = is_last;

endmodule

// ===== rtl/slip_framing_codec.sv =====
// ----------------------------------------------------------------------------
// slip_framing_codec
// full-duplex slip line framing: receive unescaping and transmit escaping
// ----------------------------------------------------------------------------
// The block takes one input item per cycle while in_full is low and
// delivers its results, one per cycle while out_pop is high, on the out_
// side. A receive byte gives at most one result, so receive traffic flows
// at one item per cycle; a transmit byte gives one to four line bytes, and
// the input stalls once the command queue fills, since the result side
// emits one transfer per cycle. The front part classifies each item in
// the cycle it is taken, a two-entry command queue sits between it and
// the back part, and the back part walks each command; a result passes a
// queue entry and the back part's command register before it shows on the
// ports. Configuration writes of max_payload take effect on the next item.
// ----------------------------------------------------------------------------
module slip_framing_codec (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  slfc_pkg::in_item_t         in_item,
  output logic                       out_empty,
  input  logic                       out_pop,
  output slfc_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [slfc_pkg::LEN_W-1:0] cfg_wdata
);

  slfc_pkg::cmd_t front_cmd, q_cmd;
  logic           front_valid, q_valid, q_pop, q_full, res_valid;
  logic           accept;

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign out_empty = !res_valid;

  // front: state and classification
  slfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (front_cmd),
    .cmd_valid (front_valid)
  );

  // command queue
  slfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_valid),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .valid    (q_valid)
  );

  // back: result expansion
  slfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res       (out_item)
  );

endmodule

// ===== rtl/slfc_checker.sv =====
// ----------------------------------------------------------------------------
// slfc_checker
// port-level checks on the slip framing codec result channel
// ----------------------------------------------------------------------------
`include "slip_framing_codec_defines.svh"

module slfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input slfc_pkg::out_item_t out_item
);

  // a frame report carries a length and no byte
  `SFC_ASSERT_IMPLY(a_frame_fields, clk, rst_n, !out_empty && out_item.kind == slfc_pkg::KIND_RX_FRAME, out_item.byte_out == 8'd0 && out_item.frame_length != '0)

  // a decoded receive byte is always the only result of its item
  `SFC_ASSERT_IMPLY(a_rx_single, clk, rst_n, !out_empty && out_item.kind == slfc_pkg::KIND_RX_BYTE, out_item.last_of_run && out_item.frame_length == '0)

  // a waiting result holds until its transfer
  `SFC_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_item))

  // nothing is shown right after reset
  `SFC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, out_empty)

endmodule

bind slip_framing_codec slfc_checker u_slfc_checker (.*);
